### src/cdist_pkg.sv
// Package for the cosine distance accumulator.
// Holds shared widths, constants and the controller/datapath command and status types.
// No dependencies.
package cdist_pkg;

  // Element width used when the top level is not overridden.
  localparam int ELEM_BITS_DEF = 16;

  // Accumulator and result widths.
  localparam int ACC_W  = 48;
  localparam int DIST_W = 16;

  // Operand and result widths of the wide multiplier.
  localparam int LIMB_W  = 32;
  localparam int WMUL_AW = 96;
  localparam int WMUL_BW = 64;
  localparam int WMUL_RW = 128;

  // Saturation bounds and fixed results.
  localparam logic signed [ACC_W-1:0] DOT_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DOT_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]        NORM_MAX = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0]       DIST_MAX = 16'h8000;
  localparam logic [DIST_W-1:0]       DIST_MIN = 16'h0000;

  // Operand selection for the wide multiplier.
  typedef enum logic [1:0] {
    MSEL_XSQ,
    MSEL_PROD,
    MSEL_RHS
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     acc_en;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     cap_xsq;
    logic     cap_prod;
    logic     search_init;
    logic     mid_calc;
    logic     msq_calc;
    logic     test_apply;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_norm;
    logic mul_done;
    logic search_done;
    logic out_free;
  } sts_t;

endpackage

### src/cdist_wmul.sv
// Multi-cycle wide multiplier: 96 x 64 bit product, truncated to 128 bits.
// One shared 32x32 multiplier walks the limb pairs; uses cdist_pkg widths.
module cdist_wmul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cdist_pkg::WMUL_AW-1:0] a,
  input  logic [cdist_pkg::WMUL_BW-1:0] b,
  output logic                          done,
  output logic [cdist_pkg::WMUL_RW-1:0] res
);

  logic                          busy_r;
  logic                          done_r;
  logic                          phase_r;
  logic [1:0]                    ia_r;
  logic                          kb_r;
  logic [cdist_pkg::WMUL_AW-1:0] a_r;
  logic [cdist_pkg::WMUL_BW-1:0] b_r;
  logic [2*cdist_pkg::LIMB_W-1:0] p_r;
  logic [cdist_pkg::WMUL_RW-1:0] acc_r;

  logic [cdist_pkg::LIMB_W-1:0]  a_limb;
  logic [cdist_pkg::LIMB_W-1:0]  b_limb;
  logic [cdist_pkg::WMUL_RW-1:0] p_shift;
  logic [2:0]                    pos;

  // Pick the current limbs
  always_comb begin
    case (ia_r)
      2'd0:    a_limb = a_r[31:0];
      2'd1:    a_limb = a_r[63:32];
      2'd2:    a_limb = a_r[95:64];
      default: a_limb = '0;
    endcase
    b_limb = kb_r ? b_r[63:32] : b_r[31:0];
  end

  // Align the partial product to its limb position
  always_comb begin
    pos = 3'(ia_r) + 3'(kb_r);
    case (pos)
      3'd0:    p_shift = cdist_pkg::WMUL_RW'(p_r);
      3'd1:    p_shift = cdist_pkg::WMUL_RW'(p_r) << 32;
      3'd2:    p_shift = cdist_pkg::WMUL_RW'(p_r) << 64;
      3'd3:    p_shift = cdist_pkg::WMUL_RW'(p_r) << 96;
      default: p_shift = '0;
    endcase
  end

  // Control: alternate a multiply phase and an add phase, then advance to the next limb pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      ia_r    <= 2'd0;
      kb_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        ia_r    <= 2'd0;
        kb_r    <= 1'b0;
      end else if (busy_r) begin
        phase_r <= !phase_r;
        if (phase_r) begin
          if (kb_r) begin
            kb_r <= 1'b0;
            if (ia_r == 2'd2) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              ia_r <= ia_r + 2'd1;
            end
          end else begin
            kb_r <= 1'b1;
          end
        end
      end
    end
  end

  // Datapath: operands, partial product, running sum
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        p_r <= a_limb * b_limb;
      end else begin
        acc_r <= acc_r + p_shift;
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

### src/cdist_datapath.sv
// Datapath: saturating accumulators, binary search registers and the result register.
// Depends on cdist_pkg and cdist_wmul.
module cdist_datapath #(
  parameter int ELEM_BITS = cdist_pkg::ELEM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [15:0]            in_elem_a,
  input  logic signed [15:0]            in_elem_b,
  input  cdist_pkg::cmd_t               cmd,
  output cdist_pkg::sts_t               sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [cdist_pkg::DIST_W-1:0]  out_distance,
  output logic                          out_zero_norm
);

  localparam int EW = ELEM_BITS;
  localparam int AW = cdist_pkg::ACC_W;

  // Element decode
  logic signed [EW-1:0] a_s;
  logic signed [EW-1:0] b_s;

  generate
    if (EW <= 16) begin : g_narrow
      assign a_s = $signed(in_elem_a[EW-1:0]);
      assign b_s = $signed(in_elem_b[EW-1:0]);
    end else begin : g_wide
      assign a_s = $signed({{(EW-16){1'b0}}, in_elem_a});
      assign b_s = $signed({{(EW-16){1'b0}}, in_elem_b});
    end
  endgenerate

  logic signed [2*EW-1:0] p_ab;
  logic signed [2*EW-1:0] p_aa;
  logic signed [2*EW-1:0] p_bb;
  logic signed [AW+1:0]   dot_w;
  logic [AW:0]            na_w;
  logic [AW:0]            nb_w;

  logic signed [AW-1:0] dot_r;
  logic [AW-1:0]        norm_a_r;
  logic [AW-1:0]        norm_b_r;
  logic signed [AW-1:0] dot_nxt;
  logic [AW-1:0]        norm_a_nxt;
  logic [AW-1:0]        norm_b_nxt;

  // Products and widened sums
  assign p_ab  = a_s * b_s;
  assign p_aa  = a_s * a_s;
  assign p_bb  = b_s * b_s;
  assign dot_w = (AW+2)'(dot_r) + (AW+2)'(p_ab);
  assign na_w  = {1'b0, norm_a_r} + (AW+1)'($unsigned(p_aa));
  assign nb_w  = {1'b0, norm_b_r} + (AW+1)'($unsigned(p_bb));

  // Saturate the sums
  always_comb begin
    if (dot_w[AW+1:AW-1] != 3'b000 && dot_w[AW+1:AW-1] != 3'b111) begin
      dot_nxt = dot_w[AW+1] ? cdist_pkg::DOT_MIN : cdist_pkg::DOT_MAX;
    end else begin
      dot_nxt = dot_w[AW-1:0];
    end
    norm_a_nxt = na_w[AW] ? cdist_pkg::NORM_MAX : na_w[AW-1:0];
    norm_b_nxt = nb_w[AW] ? cdist_pkg::NORM_MAX : nb_w[AW-1:0];
  end

  // Accumulate on each beat, clear once the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r    <= '0;
      norm_a_r <= '0;
      norm_b_r <= '0;
    end else if (cmd.out_load) begin
      dot_r    <= '0;
      norm_a_r <= '0;
      norm_b_r <= '0;
    end else if (cmd.acc_en) begin
      dot_r    <= dot_nxt;
      norm_a_r <= norm_a_nxt;
      norm_b_r <= norm_b_nxt;
    end
  end

  // Finish stage operands
  logic [AW-1:0] dot_mag;
  logic [62:0]   x_val;
  logic          dot_pos;
  logic          zero_norm;

  assign dot_mag   = dot_r[AW-1] ? AW'(-dot_r) : dot_r;
  assign x_val     = {dot_mag, 15'd0};
  assign dot_pos   = !dot_r[AW-1] && (dot_r != '0);
  assign zero_norm = (norm_a_r == '0) || (norm_b_r == '0);

  logic [cdist_pkg::WMUL_RW-1:0] xsq_r;
  logic [cdist_pkg::WMUL_AW-1:0] prod_r;
  logic [31:0]                   msq_r;
  logic [cdist_pkg::WMUL_AW-1:0] mul_a;
  logic [cdist_pkg::WMUL_BW-1:0] mul_b;
  logic [cdist_pkg::WMUL_RW-1:0] mul_res;
  logic                          mul_done;

  // Select the multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      cdist_pkg::MSEL_XSQ: begin
        mul_a = cdist_pkg::WMUL_AW'(x_val);
        mul_b = cdist_pkg::WMUL_BW'(x_val);
      end
      cdist_pkg::MSEL_PROD: begin
        mul_a = cdist_pkg::WMUL_AW'(norm_a_r);
        mul_b = cdist_pkg::WMUL_BW'(norm_b_r);
      end
      cdist_pkg::MSEL_RHS: begin
        mul_a = prod_r;
        mul_b = cdist_pkg::WMUL_BW'(msq_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cdist_wmul u_wmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Binary search over the rounded distance
  logic signed [16:0] lo_r;
  logic signed [16:0] hi_r;
  logic [15:0]        mid_r;
  logic signed [16:0] m_r;
  logic signed [16:0] span;
  logic signed [16:0] mid_w;
  logic signed [17:0] m_w;
  logic [15:0]        am;
  logic               m_neg;
  logic               test_ok;

  assign span  = hi_r - lo_r + 17'sd1;
  assign mid_w = lo_r + (span >>> 1);
  assign m_w   = 18'sd32769 - (18'(mid_w) <<< 1);
  assign am    = m_r[16] ? 16'(-m_r) : m_r[15:0];
  assign m_neg = m_r[16];

  // Is the rounded distance at least mid?
  always_comb begin
    if (!dot_pos && !m_neg) begin
      test_ok = 1'b1;
    end else if (dot_pos && m_neg) begin
      test_ok = 1'b0;
    end else if (dot_pos) begin
      test_ok = (xsq_r <= mul_res);
    end else begin
      test_ok = (xsq_r >= mul_res);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_xsq) begin
      xsq_r <= mul_res;
    end
    if (cmd.cap_prod) begin
      prod_r <= mul_res[cdist_pkg::WMUL_AW-1:0];
    end
    if (cmd.search_init) begin
      lo_r <= -17'sd1;
      hi_r <= 17'sd32768;
    end else if (cmd.test_apply) begin
      if (test_ok) begin
        lo_r <= $signed({1'b0, mid_r});
      end else begin
        hi_r <= $signed({1'b0, mid_r}) - 17'sd1;
      end
    end
    if (cmd.mid_calc) begin
      mid_r <= mid_w[15:0];
      m_r   <= m_w[16:0];
    end
    if (cmd.msq_calc) begin
      msq_r <= am * am;
    end
  end

  // Result register: load when free, drop once taken
  logic                         out_valid_r;
  logic [cdist_pkg::DIST_W-1:0] out_distance_r;
  logic                         out_zero_norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_zero_norm_r <= zero_norm;
      if (zero_norm) begin
        out_distance_r <= cdist_pkg::DIST_MAX;
      end else if (lo_r[16]) begin
        out_distance_r <= cdist_pkg::DIST_MIN;
      end else begin
        out_distance_r <= lo_r[15:0];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = out_distance_r;
  assign out_zero_norm = out_zero_norm_r;

  assign sts.zero_norm   = zero_norm;
  assign sts.mul_done    = mul_done;
  assign sts.search_done = (lo_r >= hi_r);
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Checks
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register loaded while a beat is stalled");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (dot_r == '0 && norm_a_r == '0 && norm_b_r == '0))
    else $error("accumulators not cleared after result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_distance_r <= cdist_pkg::DIST_MAX))
    else $error("distance out of range");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_norm_r) |-> (out_distance_r == cdist_pkg::DIST_MAX))
    else $error("zero norm without distance 2.0");

endmodule

### src/cdist_ctrl.sv
// Controller: sequences accumulation, the two setup multiplies and the distance search.
// Depends on cdist_pkg.
module cdist_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_elem,
  output logic            in_stall,
  input  cdist_pkg::sts_t sts,
  output cdist_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_ACC,
    S_PREP,
    S_XSQW,
    S_PROD,
    S_PRODW,
    S_MID,
    S_MSQ,
    S_RHS,
    S_RHSW,
    S_TEST,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_ACC:   if (in_valid && in_last_elem) state_nxt = S_PREP;
      S_PREP:  state_nxt = sts.zero_norm ? S_DONE : S_XSQW;
      S_XSQW:  if (sts.mul_done) state_nxt = S_PROD;
      S_PROD:  state_nxt = S_PRODW;
      S_PRODW: if (sts.mul_done) state_nxt = S_MID;
      S_MID:   state_nxt = sts.search_done ? S_DONE : S_MSQ;
      S_MSQ:   state_nxt = S_RHS;
      S_RHS:   state_nxt = S_RHSW;
      S_RHSW:  if (sts.mul_done) state_nxt = S_TEST;
      S_TEST:  state_nxt = S_MID;
      S_DONE:  if (sts.out_free) state_nxt = S_ACC;
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands from the state
  always_comb begin
    cmd = '0;
    cmd.mul_sel = cdist_pkg::MSEL_XSQ;
    case (state_r)
      S_ACC:   cmd.acc_en = in_valid;
      S_PREP: begin
        cmd.mul_start   = !sts.zero_norm;
        cmd.search_init = 1'b1;
      end
      S_XSQW:  cmd.cap_xsq = sts.mul_done;
      S_PROD: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = cdist_pkg::MSEL_PROD;
      end
      S_PRODW: cmd.cap_prod = sts.mul_done;
      S_MID:   cmd.mid_calc = !sts.search_done;
      S_MSQ:   cmd.msq_calc = 1'b1;
      S_RHS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = cdist_pkg::MSEL_RHS;
      end
      S_RHSW:  cmd.mul_sel = cdist_pkg::MSEL_RHS;
      S_TEST:  cmd.test_apply = 1'b1;
      S_DONE:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_ACC);

endmodule

### src/cosine_distance_accumulator_top.sv
// Channel  | Direction | Ports                                   | Beat
// in_      | input     | in_valid/in_stall, elem_a, elem_b, last | one element pair
// out_     | output    | out_valid/out_stall, distance, zero_norm| one distance per vector pair
//
// Element pairs are taken one per cycle while accumulating.
// After the last pair the finish is set by the single 32x32 multiplier in cdist_wmul,
// which forms each wide product limb pair by limb pair: two setup products, then
// 15 or 16 search steps of one wide product each. A zero norm skips products and search.
// The input stalls for the whole finish and while a finished result waits for a
// stalled output register. rst_n is synchronous, active low; it clears the sums
// and the controller. A taken-over result holds in the output register while
// accumulation of the next vectors resumes.
module cosine_distance_accumulator_top #(
  parameter int ELEM_BITS = cdist_pkg::ELEM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           in_elem_a,
  input  logic signed [15:0]           in_elem_b,
  input  logic                         in_last_elem,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cdist_pkg::DIST_W-1:0] out_distance,
  output logic                         out_zero_norm
);

  cdist_pkg::cmd_t cmd;
  cdist_pkg::sts_t sts;

  cdist_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_elem (in_last_elem),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  cdist_datapath #(
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_elem_a     (in_elem_a),
    .in_elem_b     (in_elem_b),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_distance  (out_distance),
    .out_zero_norm (out_zero_norm)
  );

endmodule
